// File: src/lruws_pkg.sv
`timescale 1ns / 1ps
// lruws_pkg: field widths, register codes, status codes and the control/status
// structs shared by the working set controller, datapath and checker
// no dependencies
package lruws_pkg;

	// fixed field widths of the ports
	localparam int PAGE_W     = 16;
	localparam int NOW_W      = 32;
	localparam int IDLE_W     = 16;
	localparam int SETLIM_W   = 4;
	localparam int OCC_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [IDLE_W-1:0]   IDLE_LIMIT_RST = 16'd50;
	localparam logic [SETLIM_W-1:0] SET_LIMIT_RST  = 4'd12;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_EN   = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_ADDED   = 2'd1,
		ST_REFUSED = 2'd2,
		ST_SWEEP   = 2'd3
	} status_t;

	typedef logic [PAGE_W-1:0] page_fld_t;
	typedef logic [OCC_W-1:0]  occ_fld_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;          // latch the item, restart scan
		logic rd_last;       // read the last occupied slot instead of the scan index
		logic scan_upd;      // fault scan step: track oldest, advance index
		logic idx_inc;       // sweep step: keep slot, advance index
		logic capture_gone;  // sweep: remember the expiring page
		logic move_victim;   // fault: move last slot into the victim slot
		logic move_idx;      // sweep: move last slot into the scan slot
		logic emit_hit;      // fault: report already active
		logic add;           // fault: add or refuse, report
		logic sweep_end;     // sweep: flush the held report as final
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic sweep_en;
		logic hit;
		logic scan_last;
		logic full;
		logic expired;
		logic idx_done;
	} dp_stat_t;

endpackage

// File: src/lru_working_set_idle_expiry.sv
`timescale 1ns / 1ps
// lru_working_set_idle_expiry: top level of the working set tracker
// depends on lruws_pkg, lruws_ctrl, lruws_dp
//
// Usage:
//   An item (action, page, now, check_passed) is taken at a clock edge with
//   start high and busy low. Action 0 is a page fault: exactly one result with
//   last high. Action 1 is an idle sweep: one result per expired entry, the
//   final one with last high; a sweep that expires nothing gives no result.
//   Each result shows on the result ports for one cycle with done high; the
//   receiver cannot hold it off.
//   Config writes (cfg_index 0 idle_limit, 1 set_limit, 2 sweep_enable) are a
//   transfer at cfg_valid and cfg_ready, ready is always high; write only when
//   no item is in flight.
//   Scan: the slots sit in one memory with a single registered read port,
//   so a fault scan reads, then compares, each occupied slot in turn until a
//   hit; when an eviction is needed, the last slot is then read and moved
//   into the victim slot before the add. A sweep reads and compares each slot,
//   moving the last slot into each expired slot. The result strobe is
//   registered from the last step; busy is low by then.
//   Reset: the set is empty and registers return to idle_limit 50,
//   set_limit 12, sweep_enable 1; no clearing pass is needed.
module lru_working_set_idle_expiry import lruws_pkg::*; #(
	parameter int MAX_SLOTS  = 12,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [PAGE_W-1:0]     page,
	input  logic [NOW_W-1:0]      now,
	input  logic                  check_passed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output status_t               status,
	output logic                  evicted_valid,
	output logic [PAGE_W-1:0]     evicted_page,
	output logic [OCC_W-1:0]      occupancy,
	output logic                  last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// config writes never stall
	assign cfg_ready = 1'b1;

	// sequencer
	lruws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot storage and result path
	lruws_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.page          (page),
		.now           (now),
		.check_passed  (check_passed),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.occupancy     (occupancy),
		.last          (last)
	);

endmodule

// File: src/lruws_ctrl.sv
`timescale 1ns / 1ps
// lruws_ctrl: sequencing state machine for fault and sweep items
// depends on lruws_pkg
module lruws_ctrl import lruws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     action,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	typedef enum logic [3:0] {
		IDLE,
		FLT_RD,
		FLT_CMP,
		FLT_DECIDE,
		FLT_MOVE,
		FLT_ADD,
		SWP_RD,
		SWP_CMP,
		SWP_MOVE,
		SWP_END
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!action) begin
						state_d = stat.count_zero ? FLT_DECIDE : FLT_RD;
					end else if (stat.sweep_en) begin
						state_d = SWP_RD;
					end
				end
			end
			FLT_RD: begin
				state_d = FLT_CMP;
			end
			FLT_CMP: begin
				if (stat.hit) begin
					cmd.emit_hit = 1'b1;
					state_d      = IDLE;
				end else begin
					cmd.scan_upd = 1'b1;
					state_d      = stat.scan_last ? FLT_DECIDE : FLT_RD;
				end
			end
			FLT_DECIDE: begin
				if (stat.full) begin
					cmd.rd_last = 1'b1;
					state_d     = FLT_MOVE;
				end else begin
					state_d = FLT_ADD;
				end
			end
			FLT_MOVE: begin
				cmd.move_victim = 1'b1;
				state_d         = FLT_ADD;
			end
			FLT_ADD: begin
				cmd.add = 1'b1;
				state_d = IDLE;
			end
			SWP_RD: begin
				state_d = stat.idx_done ? SWP_END : SWP_CMP;
			end
			SWP_CMP: begin
				if (stat.expired) begin
					cmd.capture_gone = 1'b1;
					cmd.rd_last      = 1'b1;
					state_d          = SWP_MOVE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = SWP_RD;
				end
			end
			SWP_MOVE: begin
				cmd.move_idx = 1'b1;
				state_d      = SWP_RD;
			end
			SWP_END: begin
				cmd.sweep_end = 1'b1;
				state_d       = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// state register and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != IDLE);
		end
	end

endmodule

// File: src/lruws_dp.sv
`timescale 1ns / 1ps
// lruws_dp: slot memory, config registers, scan counters and result registers
// depends on lruws_pkg
module lruws_dp import lruws_pkg::*; #(
	parameter int MAX_SLOTS  = 12,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PAGE_W-1:0]     page,
	input  logic [NOW_W-1:0]      now,
	input  logic                  check_passed,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic                  done,
	output status_t               status,
	output logic                  evicted_valid,
	output logic [PAGE_W-1:0]     evicted_page,
	output logic [OCC_W-1:0]      occupancy,
	output logic                  last
);

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	typedef logic [CW-1:0]         cnt_t;
	typedef logic [IW-1:0]         idx_t;
	typedef logic [PAGE_BITS-1:0]  spage_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;

	localparam cnt_t MAX_CNT = cnt_t'(MAX_SLOTS);

	// config registers
	logic [IDLE_W-1:0]   idle_limit_q;
	logic [SETLIM_W-1:0] set_limit_q;
	logic                sweep_en_q;

	// item registers
	spage_t page_q;
	stamp_t now_q;
	logic   passed_q;

	// slot memory
	spage_t page_mem [MAX_SLOTS];
	stamp_t stamp_mem[MAX_SLOTS];
	spage_t rd_page_q;
	stamp_t rd_stamp_q;
	idx_t   rd_a;
	logic   mem_we;
	idx_t   mem_wa;
	spage_t mem_wpage;
	stamp_t mem_wstamp;

	// counters and scan state
	cnt_t   count_q;
	cnt_t   idx_q;
	cnt_t   cnt_m1;
	stamp_t best_age_q;
	idx_t   victim_q;
	spage_t victim_page_q;
	spage_t gone_q;
	logic   ev_valid_q;
	spage_t ev_page_q;
	logic   pend_q;
	spage_t pend_page_q;
	cnt_t   pend_occ_q;

	// compare logic
	stamp_t      age;
	logic [31:0] lim32;
	logic        can_add;

	// result staging
	logic    emit;
	status_t e_status;
	logic    e_evv;
	spage_t  e_evp;
	cnt_t    e_occ;
	logic    e_last;

	// config write, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RST;
			set_limit_q  <= SET_LIMIT_RST;
			sweep_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IDLE_LIMIT: idle_limit_q <= cfg_data[IDLE_W-1:0];
				REG_SET_LIMIT:  set_limit_q  <= cfg_data[SETLIM_W-1:0];
				REG_SWEEP_EN:   sweep_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q   <= spage_t'(page);
			now_q    <= stamp_t'(now);
			passed_q <= check_passed;
		end
	end

	// derived values
	assign cnt_m1  = count_q - cnt_t'(1);
	assign age     = now_q - rd_stamp_q;
	assign can_add = passed_q && (count_q < MAX_CNT);

	// effective set limit: zero acts as one, clipped to the slot count
	always_comb begin
		if (set_limit_q == '0) begin
			lim32 = 32'd1;
		end else if (32'(set_limit_q) > 32'(MAX_SLOTS)) begin
			lim32 = 32'(MAX_SLOTS);
		end else begin
			lim32 = 32'(set_limit_q);
		end
	end

	// status to the controller
	always_comb begin
		stat.count_zero = (count_q == '0);
		stat.sweep_en   = sweep_en_q;
		stat.hit        = (rd_page_q == page_q);
		stat.scan_last  = ((idx_q + cnt_t'(1)) >= count_q);
		stat.full       = (32'(count_q) >= lim32);
		stat.expired    = (age > stamp_t'(idle_limit_q));
		stat.idx_done   = (idx_q >= count_q);
	end

	// memory port selection
	assign rd_a = cmd.rd_last ? cnt_m1[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		mem_we     = 1'b0;
		mem_wa     = idx_q[IW-1:0];
		mem_wpage  = rd_page_q;
		mem_wstamp = rd_stamp_q;
		unique if (cmd.move_victim) begin
			mem_we = 1'b1;
			mem_wa = victim_q;
		end else if (cmd.move_idx) begin
			mem_we = 1'b1;
		end else if (cmd.add && can_add) begin
			mem_we     = 1'b1;
			mem_wa     = count_q[IW-1:0];
			mem_wpage  = page_q;
			mem_wstamp = now_q;
		end else begin
			mem_we = 1'b0;
		end
	end

	// slot memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[mem_wa]  <= mem_wpage;
			stamp_mem[mem_wa] <= mem_wstamp;
		end
		rd_page_q  <= page_mem[rd_a];
		rd_stamp_q <= stamp_mem[rd_a];
	end

	// oldest entry tracking, strict compare keeps the lowest slot on ties
	always_ff @(posedge clk) begin
		if (cmd.scan_upd && ((idx_q == '0) || (age > best_age_q))) begin
			best_age_q    <= age;
			victim_q      <= idx_q[IW-1:0];
			victim_page_q <= rd_page_q;
		end
		if (cmd.capture_gone) begin
			gone_q <= rd_page_q;
		end
	end

	// occupancy, scan index, eviction and held-report flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			ev_valid_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q      <= '0;
				ev_valid_q <= 1'b0;
				pend_q     <= 1'b0;
			end
			if (cmd.scan_upd || cmd.idx_inc) begin
				idx_q <= idx_q + cnt_t'(1);
			end
			if (cmd.move_victim) begin
				count_q    <= cnt_m1;
				ev_valid_q <= 1'b1;
			end
			if (cmd.move_idx) begin
				count_q <= cnt_m1;
				pend_q  <= 1'b1;
			end
			if (cmd.add && can_add) begin
				count_q <= count_q + cnt_t'(1);
			end
			if (cmd.sweep_end) begin
				pend_q <= 1'b0;
			end
		end
	end

	// evicted page and held sweep report payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_page_q <= '0;
		end
		if (cmd.move_victim) begin
			ev_page_q <= victim_page_q;
		end
		if (cmd.move_idx) begin
			pend_page_q <= gone_q;
			pend_occ_q  <= cnt_m1;
		end
	end

	// result selection; a sweep report is held until the next one or the end
	always_comb begin
		emit     = 1'b0;
		e_status = ST_SWEEP;
		e_evv    = 1'b1;
		e_evp    = pend_page_q;
		e_occ    = pend_occ_q;
		e_last   = 1'b0;
		if (cmd.emit_hit) begin
			emit     = 1'b1;
			e_status = ST_HIT;
			e_evv    = 1'b0;
			e_evp    = '0;
			e_occ    = count_q;
			e_last   = 1'b1;
		end else if (cmd.add) begin
			emit     = 1'b1;
			e_status = passed_q ? ST_ADDED : ST_REFUSED;
			e_evv    = ev_valid_q;
			e_evp    = ev_page_q;
			e_occ    = can_add ? (count_q + cnt_t'(1)) : count_q;
			e_last   = 1'b1;
		end else if (cmd.move_idx) begin
			emit = pend_q;
		end else if (cmd.sweep_end) begin
			emit   = pend_q;
			e_last = 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status        <= e_status;
			evicted_valid <= e_evv;
			evicted_page  <= page_fld_t'(e_evp);
			occupancy     <= occ_fld_t'(e_occ);
			last          <= e_last;
		end
	end

endmodule

// File: src/lruws_chk.sv
`timescale 1ns / 1ps
// lruws_chk: port-level checks on the results of the working set tracker
// depends on lruws_pkg; bound to lru_working_set_idle_expiry
module lruws_chk import lruws_pkg::*; #(
	parameter int MAX_SLOTS = 12
) (
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              done,
	input status_t           status,
	input logic              evicted_valid,
	input logic [PAGE_W-1:0] evicted_page,
	input logic [OCC_W-1:0]  occupancy,
	input logic              last
);

	// a fault gives a single result
	a_fault_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_SWEEP) |-> last)
		else $error("fault result without last");

	// the final result leaves the block ready for the next item
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("busy still high on final result");

	// no eviction reports page zero
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted_valid |-> (evicted_page == '0))
		else $error("evicted page nonzero without eviction");

	// every sweep report names a removed page
	a_sweep_evicts: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_SWEEP) |-> evicted_valid)
		else $error("sweep report without eviction");

	// occupancy stays within the slot count
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(occupancy) <= 32'(MAX_SLOTS)))
		else $error("occupancy above slot count");

endmodule

bind lru_working_set_idle_expiry lruws_chk #(.MAX_SLOTS(MAX_SLOTS)) u_chk (.*);
